FILE: rtl/sac_pkg.sv
// Shared constants and codes for the set-associative write-through cache.
package sac_pkg;
   localparam int SETS_DEFAULT      = 128;
   localparam int ADDR_BITS_DEFAULT = 20;
   localparam int WAYS              = 8;
   localparam int WAY_BITS          = 3;
   localparam int LINE_BYTES        = 64;
   localparam int OFFSET_BITS       = 6;
   localparam int TAG_SHIFT         = 13;
   localparam int MAX_BYTES         = 4;

   typedef enum logic [2:0] {
      OUT_HIT         = 3'd0,
      OUT_MISS_FILL   = 3'd1,
      OUT_MISS_REPL   = 3'd2,
      OUT_BYPASS      = 3'd3,
      OUT_WRITE_MISS  = 3'd4
   } outcome_type;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;
endpackage

FILE: rtl/sac_if.sv
// Request and response channel interfaces of the cache.
interface sac_req_if #(parameter int AddrBits = sac_pkg::ADDR_BITS_DEFAULT) ();
   logic                valid;
   logic                ready;
   logic                operation;
   logic [AddrBits-1:0] address;
   logic [2:0]          byte_count;
   logic [31:0]         write_value;
   modport source (output valid, operation, address, byte_count, write_value, input ready);
   modport sink   (input valid, operation, address, byte_count, write_value, output ready);
endinterface

interface sac_rsp_if ();
   logic        valid;
   logic        ready;
   logic [31:0] read_value;
   logic [2:0]  outcome;
   modport source (output valid, read_value, outcome, input ready);
   modport sink   (input valid, read_value, outcome, output ready);
endinterface

FILE: rtl/sac_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module sac_ram #(
   parameter int AddrW = 8,
   parameter int DataW = 8
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] waddr,
   input  logic [DataW-1:0] wdata,
   input  logic [AddrW-1:0] raddr,
   output logic [DataW-1:0] rdata
);
   logic [DataW-1:0] mem [2**AddrW];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

FILE: rtl/sac_set_index.sv
// Line number modulo the set count by reciprocal multiplication, three-stage pipeline.
module sac_set_index #(
   parameter int Sets  = sac_pkg::SETS_DEFAULT,
   parameter int QW    = 14,
   parameter int SetW  = 7
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [QW-1:0]   line_num,
   output logic            done,
   output logic [SetW-1:0] set_index
);
   localparam int PW = 2 * QW + 1;
   localparam logic [QW:0] RECIP = (QW+1)'((64'd1 << QW) / 64'(Sets));

   logic            v1_ff;
   logic            v2_ff;
   logic            done_ff;
   logic [QW-1:0]   line_ff;
   logic [PW-1:0]   prod_ff;
   logic [SetW:0]   rem_est_ff;
   logic [SetW-1:0] rem_ff;
   logic [QW:0]     q_est;
   logic [QW:0]     rem_wide;

   assign q_est    = prod_ff[PW-1:QW];
   assign rem_wide = {1'b0, line_ff} - (QW+1)'(q_est * (QW+1)'(Sets));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= start;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         line_ff <= line_num;
         prod_ff <= PW'(line_num) * PW'(RECIP);
      end
      if (v1_ff) begin
         rem_est_ff <= rem_wide[SetW:0];
      end
      if (v2_ff) begin
         if (rem_est_ff >= (SetW+1)'(Sets)) begin
            rem_ff <= SetW'(rem_est_ff - (SetW+1)'(Sets));
         end else begin
            rem_ff <= SetW'(rem_est_ff);
         end
      end
   end

   assign done      = done_ff;
   assign set_index = rem_ff;
endmodule

FILE: rtl/set_assoc_write_through_cache.sv
// Eight-way set-associative write-through cache with internal backing memory.
// Requests arrive on req_ch (operation, address, byte_count, write_value) and
// one response per request leaves on rsp_ch (read_value, outcome), both under
// a valid/ready handshake. One request is worked on at a time; req_ch.ready is
// high only while the block is idle.
// From acceptance the line number is first reduced to a set; then a write
// stores its bytes, a read hit reads its bytes from the cached line,
// a read miss first fills the whole line and then writes the tag,
// and a line-crossing read takes its bytes from backing memory.
// req_ch.ready rises again in the cycle after the response is loaded.
// The rate is set by the byte-wide data ports of the backing and line memories and by the fill.
// A finished response waits in an output register; the next request can be
// accepted meanwhile, but a further result holds until rsp_ch.ready.
// After reset a clearing pass writes the tag rows in turn and invalidates every
// tag row; no request is accepted during it. Backing memory and line data are not
// cleared and must be written before being read.
module set_assoc_write_through_cache #(
   parameter int SETS      = sac_pkg::SETS_DEFAULT,
   parameter int ADDR_BITS = sac_pkg::ADDR_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   sac_req_if.sink   req_ch,
   sac_rsp_if.source rsp_ch
);
   localparam int SETW   = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int TAGW   = ADDR_BITS - sac_pkg::TAG_SHIFT;
   localparam int QW     = ADDR_BITS - sac_pkg::OFFSET_BITS;
   localparam int ROWW   = sac_pkg::WAYS * (1 + TAGW);
   localparam int LINEAW = SETW + sac_pkg::WAY_BITS + sac_pkg::OFFSET_BITS;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SETIDX, ST_TAG_RD, ST_TAG_CHK, ST_WRITE,
      ST_FILL, ST_TAG_WR, ST_RD_ISSUE, ST_RD_CAP, ST_DONE
   } state_type;

   state_type                   state_ff;
   logic                        op_ff;
   logic [ADDR_BITS-1:0]        addr_ff;
   logic [2:0]                  len_ff;
   logic [31:0]                 data_ff;
   logic [SETW-1:0]             set_ff;
   logic [SETW-1:0]             clr_ff;
   logic [sac_pkg::WAY_BITS-1:0] way_ff;
   logic                        hit_ff;
   logic                        bypass_ff;
   sac_pkg::outcome_type        outcome_ff;
   logic [31:0]                 value_ff;
   logic [6:0]                  cnt_ff;
   logic [ROWW-1:0]             row_ff;
   logic                        rsp_valid_ff;
   logic [31:0]                 rsp_value_ff;
   logic [2:0]                  rsp_outcome_ff;

   logic                 req_accept;
   logic [2:0]           len_in;
   logic                 idx_done;
   logic [SETW-1:0]      idx_set;
   logic [6:0]           pos_end;

   logic                 tag_we;
   logic [SETW-1:0]      tag_waddr;
   logic [ROWW-1:0]      tag_wdata;
   logic [ROWW-1:0]      tag_rdata;

   logic                 bm_we;
   logic [ADDR_BITS-1:0] bm_waddr;
   logic [ADDR_BITS-1:0] bm_raddr;
   logic [7:0]           bm_wdata;
   logic [7:0]           bm_rdata;

   logic                 ln_we;
   logic [LINEAW-1:0]    ln_waddr;
   logic [LINEAW-1:0]    ln_raddr;
   logic [7:0]           ln_wdata;
   logic [7:0]           ln_rdata;

   logic                 hit_any;
   logic [sac_pkg::WAY_BITS-1:0] hit_way;
   logic                 inv_any;
   logic [sac_pkg::WAY_BITS-1:0] inv_way;
   logic [ROWW-1:0]      row_upd;
   logic [TAGW-1:0]      req_tag;
   logic [6:0]           wr_off;
   logic [7:0]           wr_byte;
   logic [5:0]           rd_off;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign len_in       = (req_ch.byte_count > 3'(sac_pkg::MAX_BYTES)) ?
                         3'(sac_pkg::MAX_BYTES) : req_ch.byte_count;
   assign pos_end      = {1'b0, addr_ff[5:0]} + {4'b0, len_ff};
   assign req_tag      = addr_ff[ADDR_BITS-1:sac_pkg::TAG_SHIFT];
   assign wr_off       = {1'b0, addr_ff[5:0]} + cnt_ff;
   assign wr_byte      = 8'(data_ff >> {cnt_ff[1:0], 3'b000});
   assign rd_off       = addr_ff[5:0] + 6'(cnt_ff);

   sac_set_index #(.Sets(SETS), .QW(QW), .SetW(SETW)) u_set_index (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .line_num  (req_ch.address[ADDR_BITS-1:sac_pkg::OFFSET_BITS]),
      .done      (idx_done),
      .set_index (idx_set)
   );

   sac_ram #(.AddrW(SETW), .DataW(ROWW)) u_tag_ram (
      .clock (clock),
      .we    (tag_we),
      .waddr (tag_waddr),
      .wdata (tag_wdata),
      .raddr (set_ff),
      .rdata (tag_rdata)
   );

   sac_ram #(.AddrW(ADDR_BITS), .DataW(8)) u_backing_ram (
      .clock (clock),
      .we    (bm_we),
      .waddr (bm_waddr),
      .wdata (bm_wdata),
      .raddr (bm_raddr),
      .rdata (bm_rdata)
   );

   sac_ram #(.AddrW(LINEAW), .DataW(8)) u_line_ram (
      .clock (clock),
      .we    (ln_we),
      .waddr (ln_waddr),
      .wdata (ln_wdata),
      .raddr (ln_raddr),
      .rdata (ln_rdata)
   );

   always_comb begin
      hit_any = 1'b0;
      hit_way = '0;
      inv_any = 1'b0;
      inv_way = '0;
      for (int w = sac_pkg::WAYS - 1; w >= 0; w--) begin
         if (tag_rdata[w] && tag_rdata[sac_pkg::WAYS + w*TAGW +: TAGW] == req_tag) begin
            hit_any = 1'b1;
            hit_way = sac_pkg::WAY_BITS'(w);
         end
         if (!tag_rdata[w]) begin
            inv_any = 1'b1;
            inv_way = sac_pkg::WAY_BITS'(w);
         end
      end
   end

   always_comb begin
      row_upd = row_ff;
      row_upd[way_ff] = 1'b1;
      row_upd[sac_pkg::WAYS + 32'(way_ff)*TAGW +: TAGW] = req_tag;
   end

   always_comb begin
      tag_we    = 1'b0;
      tag_waddr = set_ff;
      tag_wdata = row_upd;
      bm_we     = 1'b0;
      bm_waddr  = addr_ff + ADDR_BITS'(cnt_ff);
      bm_wdata  = wr_byte;
      bm_raddr  = addr_ff + ADDR_BITS'(cnt_ff);
      ln_we     = 1'b0;
      ln_waddr  = {set_ff, way_ff, wr_off[5:0]};
      ln_wdata  = wr_byte;
      ln_raddr  = {set_ff, way_ff, rd_off};
      case (state_ff)
         ST_CLEAR: begin
            tag_we    = 1'b1;
            tag_waddr = clr_ff;
            tag_wdata = '0;
         end
         ST_WRITE: begin
            if (cnt_ff[2:0] != len_ff) begin
               bm_we = 1'b1;
               ln_we = hit_ff && !wr_off[6];
            end
         end
         ST_FILL: begin
            bm_raddr = {addr_ff[ADDR_BITS-1:6], cnt_ff[5:0]};
            ln_we    = (cnt_ff != 7'd0);
            ln_waddr = {set_ff, way_ff, 6'(cnt_ff - 7'd1)};
            ln_wdata = bm_rdata;
         end
         ST_TAG_WR: tag_we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == SETW'(SETS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  op_ff    <= req_ch.operation;
                  addr_ff  <= req_ch.address;
                  len_ff   <= len_in;
                  data_ff  <= req_ch.write_value;
                  value_ff <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_SETIDX;
               end
            end
            ST_SETIDX: begin
               if (idx_done) begin
                  set_ff <= idx_set;
                  if (op_ff == sac_pkg::OP_READ && pos_end > 7'(sac_pkg::LINE_BYTES)) begin
                     bypass_ff  <= 1'b1;
                     outcome_ff <= sac_pkg::OUT_BYPASS;
                     state_ff   <= ST_RD_ISSUE;
                  end else begin
                     bypass_ff <= 1'b0;
                     state_ff  <= ST_TAG_RD;
                  end
               end
            end
            ST_TAG_RD: state_ff <= ST_TAG_CHK;
            ST_TAG_CHK: begin
               row_ff <= tag_rdata;
               hit_ff <= hit_any;
               if (op_ff == sac_pkg::OP_WRITE) begin
                  way_ff     <= hit_way;
                  outcome_ff <= hit_any ? sac_pkg::OUT_HIT : sac_pkg::OUT_WRITE_MISS;
                  state_ff   <= ST_WRITE;
               end else if (hit_any) begin
                  way_ff     <= hit_way;
                  outcome_ff <= sac_pkg::OUT_HIT;
                  state_ff   <= ST_RD_ISSUE;
               end else begin
                  way_ff     <= inv_any ? inv_way : addr_ff[2:0];
                  outcome_ff <= inv_any ? sac_pkg::OUT_MISS_FILL : sac_pkg::OUT_MISS_REPL;
                  state_ff   <= ST_FILL;
               end
            end
            ST_WRITE: begin
               if (cnt_ff[2:0] == len_ff) begin
                  state_ff <= ST_DONE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_FILL: begin
               if (cnt_ff == 7'(sac_pkg::LINE_BYTES)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_TAG_WR;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_TAG_WR: state_ff <= ST_RD_ISSUE;
            ST_RD_ISSUE: begin
               state_ff <= (cnt_ff[2:0] == len_ff) ? ST_DONE : ST_RD_CAP;
            end
            ST_RD_CAP: begin
               value_ff[{cnt_ff[1:0], 3'b000} +: 8] <= bypass_ff ? bm_rdata : ln_rdata;
               cnt_ff   <= cnt_ff + 1'b1;
               state_ff <= ST_RD_ISSUE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_value_ff   <= value_ff;
                  rsp_outcome_ff <= outcome_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = rsp_value_ff;
   assign rsp_ch.outcome    = rsp_outcome_ff;
endmodule

FILE: rtl/sac_checker.sv
// Port-level assertions for the cache, bound to the top level.
module sac_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_value,
   input logic [2:0]  rsp_outcome
);
   logic [1:0] open_ff;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_ff + 2'(req_acc) - 2'(rsp_acc);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value))
      else $error("response dropped while stalled");

   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == sac_pkg::OUT_WRITE_MISS |-> rsp_read_value == 32'd0)
      else $error("write response carries data");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("response without request");

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff != 2'd3)
      else $error("too many requests outstanding");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");
endmodule

bind set_assoc_write_through_cache sac_checker u_sac_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_read_value (rsp_ch.read_value),
   .rsp_outcome    (rsp_ch.outcome)
);

FILE: verif/set_assoc_write_through_cache_tb.sv
// Self-checking testbench for the eight-way write-through cache: table and random requests.
module set_assoc_write_through_cache_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ADDR_W      = 20;
   localparam int IDLE_LIMIT  = 5000;
   localparam int RANDOM_REQS = 250;

   typedef struct {
      logic [31:0]          value;
      sac_pkg::outcome_type oc;
   } resp_t;

   typedef struct {
      logic                 op;
      logic [ADDR_W-1:0]    addr;
      logic [2:0]           cnt;
      logic [31:0]          data;
      bit                   typed;
      logic [31:0]          value;
      sac_pkg::outcome_type oc;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sac_req_if #(.AddrBits(ADDR_W)) req_ch ();
   sac_rsp_if rsp_ch ();

   set_assoc_write_through_cache #(.SETS(128), .ADDR_BITS(ADDR_W)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // cache image
   logic [7:0] mem_image [0:(1<<ADDR_W)-1];
   bit         way_valid [0:1023];
   logic [6:0] way_tag   [0:1023];
   logic [7:0] way_bytes [0:65535];
   bit         line_ready [0:16383];

   resp_t pending[$];
   int    mismatches = 0;
   int    idle_cycles = 0;
   int    stall_left = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void cache_predict(input logic op, input logic [ADDR_W-1:0] a,
                                         input logic [2:0] c, input logic [31:0] d,
                                         output resp_t r);
      int n, set, pos, hw, i, ln;
      logic [6:0]        tg;
      logic [ADDR_W-1:0] ba;
      n   = (c > 4) ? 4 : c;
      tg  = a[19:13];
      set = a[12:6];
      pos = a[5:0];
      hw  = -1;
      r.value = 32'd0;
      r.oc    = sac_pkg::OUT_HIT;
      if (op == sac_pkg::OP_READ && pos + n > sac_pkg::LINE_BYTES) begin
         for (i = 0; i < n; i++) begin
            ba = a + ADDR_W'(i);
            r.value |= 32'(mem_image[ba]) << (8 * i);
         end
         r.oc = sac_pkg::OUT_BYPASS;
         return;
      end
      for (i = 0; i < sac_pkg::WAYS; i++) begin
         if (hw < 0 && way_valid[set*sac_pkg::WAYS+i] && way_tag[set*sac_pkg::WAYS+i] == tg)
            hw = i;
      end
      if (op == sac_pkg::OP_WRITE) begin
         for (i = 0; i < n; i++) begin
            ba = a + ADDR_W'(i);
            mem_image[ba] = d[8*i +: 8];
            if (hw >= 0 && pos + i < sac_pkg::LINE_BYTES)
               way_bytes[(set*sac_pkg::WAYS+hw)*sac_pkg::LINE_BYTES+pos+i] = d[8*i +: 8];
         end
         r.oc = (hw >= 0) ? sac_pkg::OUT_HIT : sac_pkg::OUT_WRITE_MISS;
         return;
      end
      if (hw < 0) begin
         for (i = 0; i < sac_pkg::WAYS; i++) begin
            if (hw < 0 && !way_valid[set*sac_pkg::WAYS+i]) hw = i;
         end
         if (hw >= 0) r.oc = sac_pkg::OUT_MISS_FILL;
         else begin
            hw   = a[2:0];
            r.oc = sac_pkg::OUT_MISS_REPL;
         end
         ln = set*sac_pkg::WAYS + hw;
         for (i = 0; i < sac_pkg::LINE_BYTES; i++) begin
            ba = {a[ADDR_W-1:6], 6'd0} + ADDR_W'(i);
            way_bytes[ln*sac_pkg::LINE_BYTES+i] = mem_image[ba];
         end
         way_tag[ln]   = tg;
         way_valid[ln] = 1'b1;
      end
      for (i = 0; i < n; i++)
         r.value |= 32'(way_bytes[(set*sac_pkg::WAYS+hw)*sac_pkg::LINE_BYTES+pos+i])
                    << (8 * i);
   endfunction

   task automatic issue(input logic op, input logic [ADDR_W-1:0] a, input logic [2:0] c,
                        input logic [31:0] d, input bit typed, input resp_t typed_resp);
      int    gap;
      resp_t r;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.address     <= a;
      req_ch.byte_count  <= c;
      req_ch.write_value <= d;
      do @(posedge clock); while (!req_ch.ready);
      cache_predict(op, a, c, d, r);
      pending.push_back(typed ? typed_resp : r);
   endtask

   task automatic fill_line(input int ln, input bit pattern);
      int          i;
      logic [ADDR_W-1:0] a;
      logic [31:0] d;
      resp_t       none;
      none = '{32'd0, sac_pkg::OUT_HIT};
      for (i = 0; i < 16; i++) begin
         a = {ln[13:0], 6'd0} + ADDR_W'(4 * i);
         d = pattern ? {a[7:0] + 8'd3, a[7:0] + 8'd2, a[7:0] + 8'd1, a[7:0]} : $urandom;
         issue(sac_pkg::OP_WRITE, a, 3'd4, d, 1'b0, none);
      end
      line_ready[ln] = 1'b1;
   endtask

   task automatic ensure_line(input int ln);
      if (!line_ready[ln]) fill_line(ln, 1'b0);
   endtask

   function automatic logic [2:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 1) return 3'd0;
      if (r < 3) return 3'($urandom_range(5, 7));
      return 3'($urandom_range(1, 4));
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left    <= stall_left - 1;
         rsp_ch.ready  <= 1'b0;
      end else begin
         stall_left    <= pick_gap();
         rsp_ch.ready  <= 1'b1;
      end
   end

   always @(posedge clock) begin
      resp_t e;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h/%0d",
                                            rsp_ch.read_value, rsp_ch.outcome);
         end else begin
            e = pending.pop_front();
            if (rsp_ch.read_value !== e.value || rsp_ch.outcome !== e.oc) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h/%0d got %h/%0d",
                           e.value, e.oc, rsp_ch.read_value, rsp_ch.outcome);
            end
         end
      end
   end

   initial begin
      row_t  plan [$];
      resp_t tr;
      int    k, ln, pos, n, wait_cycles;
      int    pool_tags [10];
      logic [ADDR_W-1:0] a;
      logic [2:0]  c;
      logic        op;
      pool_tags = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 127};
      req_ch.valid       = 1'b0;
      req_ch.operation   = sac_pkg::OP_READ;
      req_ch.address     = '0;
      req_ch.byte_count  = 3'd1;
      req_ch.write_value = 32'd0;
      for (k = 0; k < 1024; k++) way_valid[k] = 1'b0;
      for (k = 0; k < 16384; k++) line_ready[k] = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      fill_line(0, 1'b1);
      fill_line(1, 1'b1);
      fill_line(16383, 1'b1);

      plan.push_back('{sac_pkg::OP_READ,  20'h00000, 3'd4, 32'h0, 1'b1, 32'h03020100,
                       sac_pkg::OUT_MISS_FILL});
      plan.push_back('{sac_pkg::OP_READ,  20'h0003c, 3'd4, 32'h0, 1'b1, 32'h3f3e3d3c,
                       sac_pkg::OUT_HIT});
      plan.push_back('{sac_pkg::OP_READ,  20'h0003e, 3'd4, 32'h0, 1'b1, 32'h41403f3e,
                       sac_pkg::OUT_BYPASS});
      plan.push_back('{sac_pkg::OP_READ,  20'hffffe, 3'd4, 32'h0, 1'b1, 32'h0100fffe,
                       sac_pkg::OUT_BYPASS});
      plan.push_back('{sac_pkg::OP_WRITE, 20'h00000, 3'd1, 32'hab, 1'b1, 32'h0,
                       sac_pkg::OUT_HIT});
      plan.push_back('{sac_pkg::OP_READ,  20'h00000, 3'd1, 32'h0, 1'b1, 32'h000000ab,
                       sac_pkg::OUT_HIT});
      plan.push_back('{sac_pkg::OP_WRITE, 20'h80000, 3'd2, 32'hffff, 1'b1, 32'h0,
                       sac_pkg::OUT_WRITE_MISS});
      plan.push_back('{sac_pkg::OP_WRITE, 20'h0003e, 3'd4, 32'hdeadbeef, 1'b0, 32'h0,
                       sac_pkg::OUT_HIT});
      plan.push_back('{sac_pkg::OP_READ,  20'h0003c, 3'd4, 32'h0, 1'b0, 32'h0,
                       sac_pkg::OUT_HIT});
      plan.push_back('{sac_pkg::OP_READ,  20'h00040, 3'd4, 32'h0, 1'b0, 32'h0,
                       sac_pkg::OUT_HIT});
      plan.push_back('{sac_pkg::OP_READ,  20'h00000, 3'd0, 32'h0, 1'b0, 32'h0,
                       sac_pkg::OUT_HIT});
      plan.push_back('{sac_pkg::OP_READ,  20'hfffc0, 3'd7, 32'h0, 1'b0, 32'h0,
                       sac_pkg::OUT_HIT});
      plan.push_back('{sac_pkg::OP_WRITE, 20'hfffff, 3'd7, 32'h12345678, 1'b0, 32'h0,
                       sac_pkg::OUT_HIT});
      plan.push_back('{sac_pkg::OP_READ,  20'hfffff, 3'd1, 32'h0, 1'b0, 32'h0,
                       sac_pkg::OUT_HIT});
      plan.push_back('{sac_pkg::OP_WRITE, 20'h7ffff, 3'd3, 32'h0, 1'b0, 32'h0,
                       sac_pkg::OUT_HIT});
      plan.push_back('{sac_pkg::OP_READ,  20'h00038, 3'd5, 32'h0, 1'b0, 32'h0,
                       sac_pkg::OUT_HIT});
      foreach (plan[i]) begin
         tr = '{plan[i].value, plan[i].oc};
         issue(plan[i].op, plan[i].addr, plan[i].cnt, plan[i].data, plan[i].typed, tr);
      end

      // hold the sender until the queue drains
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);

      tr = '{32'd0, sac_pkg::OUT_HIT};
      for (k = 0; k < RANDOM_REQS; k++) begin
         c  = pick_count();
         op = ($urandom_range(0, 1) == 1) ? sac_pkg::OP_WRITE : sac_pkg::OP_READ;
         ln = pool_tags[$urandom_range(0, 9)] * 128;
         pos = $urandom_range(0, 63);
         if (op == sac_pkg::OP_READ) begin
            ensure_line(ln);
            n = (c > 4) ? 4 : c;
            if (pos + n > sac_pkg::LINE_BYTES && !line_ready[(ln + 1) % 16384])
               pos = sac_pkg::LINE_BYTES - n;
            a = {ln[13:0], pos[5:0]};
         end else if ($urandom_range(0, 9) < 4) begin
            a = {ln[13:0], pos[5:0]};
         end else begin
            a = ADDR_W'($urandom);
         end
         issue(op, a, c, $urandom, 1'b0, tr);
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      wait_cycles = 0;
      while (wait_cycles < 200) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (mismatches == 0 && pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

FILE: set_assoc_write_through_cache.f
rtl/sac_pkg.sv
rtl/sac_if.sv
rtl/sac_ram.sv
rtl/sac_set_index.sv
rtl/set_assoc_write_through_cache.sv
rtl/sac_checker.sv
verif/set_assoc_write_through_cache_tb.sv
